FILE: rtl/genset_start_stop_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Generator-set sequencer assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef GENSET_START_STOP_SEQUENCER_ASSERT_SVH
`define GENSET_START_STOP_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset
`define GSS_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset
`define GSS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define GSS_ASSERT_PROP(lbl, clk, rst, prop, msg)
`define GSS_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// Generator-set sequencer package
// Codes, state encodings and payload types shared by the sequencer files.
// ----------------------------------------------------------------------------
package gss_pkg;

   // Field and register widths
   localparam int DELAY_WIDTH_DEFAULT = 16;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH     = 2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_DELAY = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_DELAY  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNLOAD      = 2'd2;

   // Event codes; the unused code acts as a tick
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_AUTO_START  = 3'd1;
   localparam logic [2:0] CMD_AUTO_STOP   = 3'd2;
   localparam logic [2:0] CMD_EMERG_STOP  = 3'd3;
   localparam logic [2:0] CMD_SHUTDOWN    = 3'd4;
   localparam logic [2:0] CMD_ALARM_RESET = 3'd5;
   localparam logic [2:0] CMD_SET_MODE    = 3'd6;

   // Engine status levels
   localparam logic [1:0] ENGST_IDLE    = 2'd0;
   localparam logic [1:0] ENGST_WORKING = 2'd1;

   // Engine commands
   localparam logic [2:0] ENG_NONE      = 3'd0;
   localparam logic [2:0] ENG_START     = 3'd1;
   localparam logic [2:0] ENG_PLAN_STOP = 3'd2;
   localparam logic [2:0] ENG_ESTOP     = 3'd3;
   localparam logic [2:0] ENG_RESET     = 3'd4;

   // Transfer commands
   localparam logic [2:0] XFR_NONE   = 3'd0;
   localparam logic [2:0] XFR_MAINS  = 3'd1;
   localparam logic [2:0] XFR_GEN    = 3'd2;
   localparam logic [2:0] XFR_UNLOAD = 3'd3;
   localparam logic [2:0] XFR_RESET  = 3'd4;

   // Controller status codes as reported on the result channel
   localparam logic [2:0] STC_IDLE      = 3'd0;
   localparam logic [2:0] STC_START     = 3'd1;
   localparam logic [2:0] STC_START_DLY = 3'd2;
   localparam logic [2:0] STC_WORK      = 3'd3;
   localparam logic [2:0] STC_STOP      = 3'd4;
   localparam logic [2:0] STC_STOP_DLY  = 3'd5;
   localparam logic [2:0] STC_ERROR     = 3'd6;

   // Controller state
   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_START     = 7'b0000010,
      ST_START_DLY = 7'b0000100,
      ST_WORK      = 7'b0001000,
      ST_STOP      = 7'b0010000,
      ST_STOP_DLY  = 7'b0100000,
      ST_ERROR     = 7'b1000000
   } status_type;

   // Start sub-steps
   typedef enum logic [5:0] {
      SS_IDLE      = 6'b000001,
      SS_DELAY     = 6'b000010,
      SS_ARM       = 6'b000100,
      SS_CRANK     = 6'b001000,
      SS_WAIT_RUN  = 6'b010000,
      SS_WAIT_LOAD = 6'b100000
   } start_step_type;

   // Stop sub-steps
   typedef enum logic [4:0] {
      PS_IDLE       = 5'b00001,
      PS_DELAY      = 5'b00010,
      PS_TRANSFER   = 5'b00100,
      PS_WAIT_MAINS = 5'b01000,
      PS_WAIT_STOP  = 5'b10000
   } stop_step_type;

   // Sequencer state apart from the delay counter
   typedef struct packed {
      status_type     status;
      logic           auto_mode;
      start_step_type start_step;
      stop_step_type  stop_step;
      logic           error_after_stop;
      logic           start_lamp;
      logic           stop_lamp;
   } seq_state_type;

   // Input transaction
   typedef struct packed {
      logic [2:0] command;
      logic       with_delay;
      logic       mode_select;
      logic [1:0] engine_state;
      logic       generator_on_load;
      logic       mains_on_load;
      logic       remote_start_high;
      logic       start_banned;
      logic       ban_auto_start;
      logic       ban_auto_shutdown;
      logic       ban_generator_load;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0] controller_status;
      logic       auto_mode;
      logic [2:0] engine_command;
      logic [2:0] transfer_command;
      logic       start_lamp;
      logic       stop_lamp;
      logic       delay_running;
   } rsp_type;

   // Map the one-hot state to its reported code
   function automatic logic [2:0] status_code(status_type s);
      logic [2:0] code;
      case (s)
         ST_IDLE:      code = STC_IDLE;
         ST_START:     code = STC_START;
         ST_START_DLY: code = STC_START_DLY;
         ST_WORK:      code = STC_WORK;
         ST_STOP:      code = STC_STOP;
         ST_STOP_DLY:  code = STC_STOP_DLY;
         ST_ERROR:     code = STC_ERROR;
         default:      code = STC_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/gss_req_if.sv
// ----------------------------------------------------------------------------
// Sequencer input channel
// Valid/ready channel carrying one event transaction per control tick.
// ----------------------------------------------------------------------------
interface gss_req_if;
   logic             valid;
   logic             ready;
   gss_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gss_rsp_if.sv
// ----------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel carrying one result transaction per control tick.
// ----------------------------------------------------------------------------
interface gss_rsp_if;
   logic             valid;
   logic             ready;
   gss_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gss_step.sv
// ----------------------------------------------------------------------------
// Sequencer tick logic
// Next state, delay counter and commands for one event transaction.
// ----------------------------------------------------------------------------
module gss_step #(
   parameter int DELAY_WIDTH = gss_pkg::DELAY_WIDTH_DEFAULT
) (
   input  gss_pkg::seq_state_type state_i,
   input  logic [DELAY_WIDTH-1:0] count_i,
   input  gss_pkg::req_type       req_i,
   input  logic [DELAY_WIDTH-1:0] start_load_i,
   input  logic [DELAY_WIDTH-1:0] stop_load_i,
   input  logic                   unload_i,
   output gss_pkg::seq_state_type state_o,
   output logic [DELAY_WIDTH-1:0] count_o,
   output gss_pkg::rsp_type       rsp_o
);

   gss_pkg::seq_state_type st;
   logic [DELAY_WIDTH-1:0] cnt;
   logic [2:0]             eng;
   logic [2:0]             xfr;
   logic                   run_start;
   logic                   run_stop;
   logic                   delayed;
   logic                   delay_on;

   always_comb begin
      st        = state_i;
      cnt       = count_i;
      eng       = gss_pkg::ENG_NONE;
      xfr       = gss_pkg::XFR_NONE;
      run_start = 1'b0;
      run_stop  = 1'b0;
      delayed   = 1'b0;

      // Requests and mode changes act first
      case (req_i.command)
         gss_pkg::CMD_AUTO_START: begin
            if (!req_i.start_banned && st.auto_mode && !req_i.ban_auto_start &&
                st.status == gss_pkg::ST_IDLE) begin
               st.status     = req_i.with_delay ? gss_pkg::ST_START_DLY : gss_pkg::ST_START;
               st.start_step = gss_pkg::SS_IDLE;
               st.stop_step  = gss_pkg::PS_IDLE;
            end
         end
         gss_pkg::CMD_AUTO_STOP: begin
            if (st.auto_mode && !req_i.ban_auto_shutdown &&
                st.status == gss_pkg::ST_WORK) begin
               st.status     = req_i.with_delay ? gss_pkg::ST_STOP_DLY : gss_pkg::ST_STOP;
               st.start_step = gss_pkg::SS_IDLE;
               st.stop_step  = gss_pkg::PS_IDLE;
            end
         end
         gss_pkg::CMD_ALARM_RESET: begin
            if (st.status == gss_pkg::ST_ERROR || st.status == gss_pkg::ST_IDLE) begin
               st.status    = gss_pkg::ST_IDLE;
               cnt          = '0;
               st.auto_mode = 1'b0;
               eng          = gss_pkg::ENG_RESET;
               xfr          = gss_pkg::XFR_RESET;
            end
         end
         gss_pkg::CMD_SET_MODE: begin
            st.auto_mode = req_i.mode_select;
         end
         default: begin
         end
      endcase

      // Pick the sequence to advance this tick
      if (st.status != gss_pkg::ST_ERROR) begin
         if (!st.auto_mode) begin
            if (req_i.engine_state == gss_pkg::ENGST_WORKING &&
                st.status == gss_pkg::ST_START) begin
               st.status = gss_pkg::ST_WORK;
            end
            run_stop = (st.status == gss_pkg::ST_STOP);
         end else begin
            case (st.status)
               gss_pkg::ST_START:     run_start = !req_i.ban_auto_start;
               gss_pkg::ST_START_DLY: begin
                  run_start = 1'b1;
                  delayed   = 1'b1;
               end
               gss_pkg::ST_STOP:      run_stop = !req_i.ban_auto_shutdown;
               gss_pkg::ST_STOP_DLY: begin
                  run_stop = 1'b1;
                  delayed  = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      // Start sequence
      if (run_start) begin
         case (st.start_step)
            gss_pkg::SS_IDLE: begin
               if (!req_i.start_banned) begin
                  if (delayed) begin
                     cnt           = start_load_i;
                     st.start_step = gss_pkg::SS_DELAY;
                  end else begin
                     st.start_step = gss_pkg::SS_ARM;
                  end
               end
            end
            gss_pkg::SS_DELAY: begin
               if (cnt == '0) begin
                  st.start_step = gss_pkg::SS_ARM;
               end else begin
                  cnt = cnt - DELAY_WIDTH'(1);
               end
               // Remote start dropped: cancel the pending start
               if (!req_i.remote_start_high) begin
                  st.status     = gss_pkg::ST_IDLE;
                  st.start_step = gss_pkg::SS_IDLE;
                  cnt           = '0;
               end
            end
            gss_pkg::SS_ARM: begin
               st.start_lamp = 1'b1;
               st.stop_lamp  = 1'b0;
               if (unload_i && !req_i.ban_generator_load) begin
                  xfr = gss_pkg::XFR_UNLOAD;
               end
               st.start_step = gss_pkg::SS_CRANK;
            end
            gss_pkg::SS_CRANK: begin
               eng           = gss_pkg::ENG_START;
               st.start_step = gss_pkg::SS_WAIT_RUN;
            end
            gss_pkg::SS_WAIT_RUN: begin
               if (req_i.engine_state == gss_pkg::ENGST_WORKING &&
                   !req_i.ban_generator_load) begin
                  xfr           = gss_pkg::XFR_GEN;
                  st.start_step = gss_pkg::SS_WAIT_LOAD;
               end
            end
            gss_pkg::SS_WAIT_LOAD: begin
               if (req_i.generator_on_load) begin
                  st.status     = gss_pkg::ST_WORK;
                  st.start_step = gss_pkg::SS_IDLE;
               end
            end
            default: begin
               st.start_step = gss_pkg::SS_IDLE;
            end
         endcase
      end

      // Stop sequence
      if (run_stop) begin
         case (st.stop_step)
            gss_pkg::PS_IDLE: begin
               if (delayed) begin
                  cnt          = stop_load_i;
                  st.stop_step = gss_pkg::PS_DELAY;
               end else begin
                  st.stop_step = gss_pkg::PS_TRANSFER;
               end
            end
            gss_pkg::PS_DELAY: begin
               if (cnt == '0) begin
                  st.stop_step = gss_pkg::PS_TRANSFER;
               end else begin
                  cnt = cnt - DELAY_WIDTH'(1);
               end
               // Remote start raised: stay at work
               if (req_i.remote_start_high) begin
                  st.status    = gss_pkg::ST_WORK;
                  st.stop_step = gss_pkg::PS_IDLE;
                  cnt          = '0;
               end
            end
            gss_pkg::PS_TRANSFER: begin
               if (req_i.generator_on_load) begin
                  xfr = gss_pkg::XFR_MAINS;
               end
               st.stop_step = gss_pkg::PS_WAIT_MAINS;
            end
            gss_pkg::PS_WAIT_MAINS: begin
               if (req_i.mains_on_load) begin
                  eng          = gss_pkg::ENG_PLAN_STOP;
                  st.stop_step = gss_pkg::PS_WAIT_STOP;
               end
            end
            gss_pkg::PS_WAIT_STOP: begin
               if (req_i.engine_state == gss_pkg::ENGST_IDLE) begin
                  st.start_lamp = 1'b0;
                  st.stop_lamp  = 1'b1;
                  if (st.error_after_stop) begin
                     st.status           = gss_pkg::ST_ERROR;
                     st.error_after_stop = 1'b0;
                  end else begin
                     st.status = gss_pkg::ST_IDLE;
                  end
                  st.stop_step = gss_pkg::PS_IDLE;
               end
            end
            default: begin
               st.stop_step = gss_pkg::PS_IDLE;
            end
         endcase
      end

      // Emergency stop and shutdown act last and override the status set above
      if (req_i.command == gss_pkg::CMD_EMERG_STOP) begin
         xfr           = gss_pkg::XFR_MAINS;
         eng           = gss_pkg::ENG_ESTOP;
         st.auto_mode  = 1'b0;
         st.status     = gss_pkg::ST_ERROR;
         st.start_lamp = 1'b0;
         st.stop_lamp  = 1'b1;
      end else if (req_i.command == gss_pkg::CMD_SHUTDOWN) begin
         if (st.status != gss_pkg::ST_ERROR) begin
            st.auto_mode        = 1'b0;
            st.status           = gss_pkg::ST_STOP;
            st.error_after_stop = 1'b1;
         end
      end

      delay_on = (st.status == gss_pkg::ST_START_DLY && st.start_step == gss_pkg::SS_DELAY) ||
                 (st.status == gss_pkg::ST_STOP_DLY && st.stop_step == gss_pkg::PS_DELAY);
   end

   // Drive the next state and the result transaction
   assign state_o = st;
   assign count_o = cnt;

   assign rsp_o.controller_status = gss_pkg::status_code(st.status);
   assign rsp_o.auto_mode         = st.auto_mode;
   assign rsp_o.engine_command    = eng;
   assign rsp_o.transfer_command  = xfr;
   assign rsp_o.start_lamp        = st.start_lamp;
   assign rsp_o.stop_lamp         = st.stop_lamp;
   assign rsp_o.delay_running     = delay_on;

endmodule

FILE: rtl/genset_start_stop_sequencer.sv
// ----------------------------------------------------------------------------
// Generator-set start/stop sequencer
// Runs the start and stop sequences of a generator set, one event per tick.
// ----------------------------------------------------------------------------
//
//   Port      Direction  Carries
//   req_chan  sink       event transaction: command and input levels
//   rsp_chan  source     result transaction: status, commands, lamps
//   csr_*     in         write port for delays and unload option
//
// One transaction per cycle is sustained while the result channel is ready;
// a result reaches the result channel through the input register, then the
// result register. The tick logic is combinational off the state registers,
// so each event sees everything that the previous one left.
// Reset is synchronous and clears state, configuration and both valids.
// A stalled result holds the result register; the input register still
// takes a new event whenever it is empty.
// ----------------------------------------------------------------------------
`include "genset_start_stop_sequencer_assert.svh"

module genset_start_stop_sequencer #(
   parameter int DELAY_WIDTH = gss_pkg::DELAY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   gss_req_if.sink                             req_chan,
   gss_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [gss_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gss_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CFG_WIDTH = gss_pkg::CSR_DATA_WIDTH;

   localparam gss_pkg::seq_state_type STATE_RESET = '{
      status:           gss_pkg::ST_IDLE,
      auto_mode:        1'b0,
      start_step:       gss_pkg::SS_IDLE,
      stop_step:        gss_pkg::PS_IDLE,
      error_after_stop: 1'b0,
      start_lamp:       1'b0,
      stop_lamp:        1'b1
   };

   logic                   in_valid_ff;
   gss_pkg::req_type       in_data_ff;
   logic                   out_valid_ff;
   gss_pkg::rsp_type       out_data_ff;
   gss_pkg::seq_state_type state_ff;
   gss_pkg::seq_state_type state_in;
   logic [DELAY_WIDTH-1:0] count_ff;
   logic [DELAY_WIDTH-1:0] count_in;
   logic [DELAY_WIDTH-1:0] start_load_ff;
   logic [DELAY_WIDTH-1:0] stop_load_ff;
   logic                   unload_ff;
   logic [DELAY_WIDTH-1:0] load_sat;
   gss_pkg::rsp_type       rsp_in;
   logic                   advance;

   // Saturate the written delay to the counter width
   generate
      if (DELAY_WIDTH >= CFG_WIDTH) begin : g_delay_wide
         assign load_sat = DELAY_WIDTH'(csr_wdata);
      end else begin : g_delay_narrow
         assign load_sat = (|csr_wdata[CFG_WIDTH-1:DELAY_WIDTH]) ? '1
                                                                 : csr_wdata[DELAY_WIDTH-1:0];
      end
   endgenerate

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_load_ff <= '0;
         stop_load_ff  <= '0;
         unload_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            gss_pkg::CSR_START_DELAY: start_load_ff <= load_sat;
            gss_pkg::CSR_STOP_DELAY:  stop_load_ff  <= load_sat;
            gss_pkg::CSR_UNLOAD:      unload_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Advance when an event waits and the result register is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.data;
      end
   end

   gss_step #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_step (
      .state_i      (state_ff),
      .count_i      (count_ff),
      .req_i        (in_data_ff),
      .start_load_i (start_load_ff),
      .stop_load_i  (stop_load_ff),
      .unload_i     (unload_ff),
      .state_o      (state_in),
      .count_o      (count_in),
      .rsp_o        (rsp_in)
   );

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         count_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   // Lamps always show opposite levels
   `GSS_ASSERT_NEVER(a_lamps_opposite, clock, reset,
      state_ff.start_lamp == state_ff.stop_lamp, "start and stop lamps agree")

   // A taken event always lands in the result register
   `GSS_ASSERT_PROP(a_advance_lands, clock, reset,
      advance |=> out_valid_ff, "advanced event produced no result")

   // The delay flag only shows in a delayed status
   `GSS_ASSERT_PROP(a_delay_status, clock, reset,
      (out_valid_ff && out_data_ff.delay_running) |->
         (out_data_ff.controller_status == gss_pkg::STC_START_DLY ||
          out_data_ff.controller_status == gss_pkg::STC_STOP_DLY),
      "delay running outside a delayed status")

endmodule

FILE: test/genset_start_stop_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generator-set start/stop sequencer testbench
// Drives event transactions through a directed table and then through
// state-aware random sequences across several idling and configuration
// phases. Each result is compared field by field against a typed row's value
// or a tick-accurate software copy of the sequencer kept in this file.
// ----------------------------------------------------------------------------
module genset_start_stop_sequencer_test;

   // Codes that the package leaves unnamed
   localparam logic [2:0] CMD_UNUSED        = 3'd7;
   localparam logic [1:0] ENGST_IDLE_SPEED  = 2'd2;
   localparam logic [1:0] ENGST_OTHER       = 2'd3;

   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int REQ_BITS        = $bits(gss_pkg::req_type);

   // One row of the directed table
   typedef struct {
      gss_pkg::req_type req;
      bit               typed;
      gss_pkg::rsp_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [gss_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [gss_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   gss_req_if req_chan ();
   gss_rsp_if rsp_chan ();

   genset_start_stop_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Configuration copy
   logic [15:0] cfg_start_delay;
   logic [15:0] cfg_stop_delay;
   logic        cfg_unload;

   // Sequencer copy
   logic [2:0]              seq_status;
   logic                    seq_auto;
   gss_pkg::start_step_type seq_start_step;
   gss_pkg::stop_step_type  seq_stop_step;
   logic [15:0]             seq_delay;
   logic                    seq_fault_after_stop;
   logic                    seq_start_lamp;
   logic                    seq_stop_lamp;
   logic [2:0]              tick_eng;
   logic [2:0]              tick_xfr;

   gss_pkg::rsp_type expected_tick_results[$];
   plan_row_type     plan[$];
   int               mismatches = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   bit               hold_request = 1'b0;
   int               hold_left = 0;

   // Per-phase settings of the random part
   int          phase_idle[4]        = '{0, 80, 0, 19};
   int          phase_stall[4]       = '{0, 0, 80, 19};
   logic [15:0] phase_start_delay[4] = '{16'd2, 16'hFFFF, 16'd0, 16'd5};
   logic [15:0] phase_stop_delay[4]  = '{16'd3, 16'hFFFF, 16'd0, 16'd1};
   logic        phase_unload[4]      = '{1'b1, 1'b0, 1'b1, 1'b0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Start sequence, one sub-step per tick
   function automatic void advance_start(gss_pkg::req_type r, bit delayed);
      case (seq_start_step)
         gss_pkg::SS_IDLE: begin
            if (!r.start_banned) begin
               if (delayed) begin
                  seq_delay      = cfg_start_delay;
                  seq_start_step = gss_pkg::SS_DELAY;
               end else begin
                  seq_start_step = gss_pkg::SS_ARM;
               end
            end
         end
         gss_pkg::SS_DELAY: begin
            if (seq_delay == '0) begin
               seq_start_step = gss_pkg::SS_ARM;
            end else begin
               seq_delay = seq_delay - 16'd1;
            end
            // a dropped remote start cancels the delay
            if (!r.remote_start_high) begin
               seq_status     = gss_pkg::STC_IDLE;
               seq_start_step = gss_pkg::SS_IDLE;
               seq_delay      = '0;
            end
         end
         gss_pkg::SS_ARM: begin
            seq_start_lamp = 1'b1;
            seq_stop_lamp  = 1'b0;
            if (cfg_unload && !r.ban_generator_load) tick_xfr = gss_pkg::XFR_UNLOAD;
            seq_start_step = gss_pkg::SS_CRANK;
         end
         gss_pkg::SS_CRANK: begin
            tick_eng       = gss_pkg::ENG_START;
            seq_start_step = gss_pkg::SS_WAIT_RUN;
         end
         gss_pkg::SS_WAIT_RUN: begin
            if (r.engine_state == gss_pkg::ENGST_WORKING && !r.ban_generator_load) begin
               tick_xfr       = gss_pkg::XFR_GEN;
               seq_start_step = gss_pkg::SS_WAIT_LOAD;
            end
         end
         gss_pkg::SS_WAIT_LOAD: begin
            if (r.generator_on_load) begin
               seq_status     = gss_pkg::STC_WORK;
               seq_start_step = gss_pkg::SS_IDLE;
            end
         end
         default: seq_start_step = gss_pkg::SS_IDLE;
      endcase
   endfunction

   // Stop sequence, one sub-step per tick
   function automatic void advance_stop(gss_pkg::req_type r, bit delayed);
      case (seq_stop_step)
         gss_pkg::PS_IDLE: begin
            if (delayed) begin
               seq_delay     = cfg_stop_delay;
               seq_stop_step = gss_pkg::PS_DELAY;
            end else begin
               seq_stop_step = gss_pkg::PS_TRANSFER;
            end
         end
         gss_pkg::PS_DELAY: begin
            if (seq_delay == '0) begin
               seq_stop_step = gss_pkg::PS_TRANSFER;
            end else begin
               seq_delay = seq_delay - 16'd1;
            end
            // a raised remote start returns to work
            if (r.remote_start_high) begin
               seq_status    = gss_pkg::STC_WORK;
               seq_stop_step = gss_pkg::PS_IDLE;
               seq_delay     = '0;
            end
         end
         gss_pkg::PS_TRANSFER: begin
            if (r.generator_on_load) tick_xfr = gss_pkg::XFR_MAINS;
            seq_stop_step = gss_pkg::PS_WAIT_MAINS;
         end
         gss_pkg::PS_WAIT_MAINS: begin
            if (r.mains_on_load) begin
               tick_eng      = gss_pkg::ENG_PLAN_STOP;
               seq_stop_step = gss_pkg::PS_WAIT_STOP;
            end
         end
         gss_pkg::PS_WAIT_STOP: begin
            if (r.engine_state == gss_pkg::ENGST_IDLE) begin
               seq_start_lamp = 1'b0;
               seq_stop_lamp  = 1'b1;
               if (seq_fault_after_stop) begin
                  seq_status           = gss_pkg::STC_ERROR;
                  seq_fault_after_stop = 1'b0;
               end else begin
                  seq_status = gss_pkg::STC_IDLE;
               end
               seq_stop_step = gss_pkg::PS_IDLE;
            end
         end
         default: seq_stop_step = gss_pkg::PS_IDLE;
      endcase
   endfunction

   // Work out the result of one control tick and advance the copy
   function automatic gss_pkg::rsp_type sequencer_tick(gss_pkg::req_type r);
      gss_pkg::rsp_type o;
      tick_eng = gss_pkg::ENG_NONE;
      tick_xfr = gss_pkg::XFR_NONE;

      // requests that act before the sequencing step
      case (r.command)
         gss_pkg::CMD_AUTO_START: begin
            if (!r.start_banned && seq_auto && !r.ban_auto_start &&
                seq_status == gss_pkg::STC_IDLE) begin
               seq_status     = r.with_delay ? gss_pkg::STC_START_DLY : gss_pkg::STC_START;
               seq_start_step = gss_pkg::SS_IDLE;
               seq_stop_step  = gss_pkg::PS_IDLE;
            end
         end
         gss_pkg::CMD_AUTO_STOP: begin
            if (seq_auto && !r.ban_auto_shutdown && seq_status == gss_pkg::STC_WORK) begin
               seq_status     = r.with_delay ? gss_pkg::STC_STOP_DLY : gss_pkg::STC_STOP;
               seq_start_step = gss_pkg::SS_IDLE;
               seq_stop_step  = gss_pkg::PS_IDLE;
            end
         end
         gss_pkg::CMD_ALARM_RESET: begin
            if (seq_status == gss_pkg::STC_ERROR || seq_status == gss_pkg::STC_IDLE) begin
               seq_status = gss_pkg::STC_IDLE;
               seq_delay  = '0;
               seq_auto   = 1'b0;
               tick_eng   = gss_pkg::ENG_RESET;
               tick_xfr   = gss_pkg::XFR_RESET;
            end
         end
         gss_pkg::CMD_SET_MODE: seq_auto = r.mode_select;
         default: ;
      endcase

      // sequencing step
      if (seq_status != gss_pkg::STC_ERROR) begin
         if (!seq_auto) begin
            if (r.engine_state == gss_pkg::ENGST_WORKING && seq_status == gss_pkg::STC_START)
               seq_status = gss_pkg::STC_WORK;
            if (seq_status == gss_pkg::STC_STOP) advance_stop(r, 1'b0);
         end else begin
            case (seq_status)
               gss_pkg::STC_START:     if (!r.ban_auto_start) advance_start(r, 1'b0);
               gss_pkg::STC_START_DLY: advance_start(r, 1'b1);
               gss_pkg::STC_STOP:      if (!r.ban_auto_shutdown) advance_stop(r, 1'b0);
               gss_pkg::STC_STOP_DLY:  advance_stop(r, 1'b1);
               default: ;
            endcase
         end
      end

      // emergency stop and shutdown override the step
      if (r.command == gss_pkg::CMD_EMERG_STOP) begin
         tick_xfr       = gss_pkg::XFR_MAINS;
         tick_eng       = gss_pkg::ENG_ESTOP;
         seq_auto       = 1'b0;
         seq_status     = gss_pkg::STC_ERROR;
         seq_start_lamp = 1'b0;
         seq_stop_lamp  = 1'b1;
      end else if (r.command == gss_pkg::CMD_SHUTDOWN) begin
         if (seq_status != gss_pkg::STC_ERROR) begin
            seq_auto             = 1'b0;
            seq_status           = gss_pkg::STC_STOP;
            seq_fault_after_stop = 1'b1;
         end
      end

      o.controller_status = seq_status;
      o.auto_mode         = seq_auto;
      o.engine_command    = tick_eng;
      o.transfer_command  = tick_xfr;
      o.start_lamp        = seq_start_lamp;
      o.stop_lamp         = seq_stop_lamp;
      o.delay_running     = (seq_status == gss_pkg::STC_START_DLY &&
                             seq_start_step == gss_pkg::SS_DELAY) ||
                            (seq_status == gss_pkg::STC_STOP_DLY &&
                             seq_stop_step == gss_pkg::PS_DELAY);
      return o;
   endfunction

   function automatic gss_pkg::req_type mk_req(logic [2:0] cmd, logic dly, logic msel,
                                               logic [1:0] eng, logic gen, logic mains,
                                               logic remote, logic banned, logic bas,
                                               logic bash, logic bgl);
      gss_pkg::req_type r;
      r.command            = cmd;
      r.with_delay         = dly;
      r.mode_select        = msel;
      r.engine_state       = eng;
      r.generator_on_load  = gen;
      r.mains_on_load      = mains;
      r.remote_start_high  = remote;
      r.start_banned       = banned;
      r.ban_auto_start     = bas;
      r.ban_auto_shutdown  = bash;
      r.ban_generator_load = bgl;
      return r;
   endfunction

   function automatic gss_pkg::rsp_type mk_rsp(logic [2:0] status, logic auto_on,
                                               logic [2:0] eng, logic [2:0] xfr,
                                               logic slamp, logic plamp, logic dly);
      gss_pkg::rsp_type o;
      o.controller_status = status;
      o.auto_mode         = auto_on;
      o.engine_command    = eng;
      o.transfer_command  = xfr;
      o.start_lamp        = slamp;
      o.stop_lamp         = plamp;
      o.delay_running     = dly;
      return o;
   endfunction

   function automatic plan_row_type row(gss_pkg::req_type r);
      plan_row_type p;
      p.req   = r;
      p.typed = 1'b0;
      p.want  = '0;
      return p;
   endfunction

   function automatic plan_row_type typed_row(gss_pkg::req_type r, gss_pkg::rsp_type w);
      plan_row_type p;
      p.req   = r;
      p.typed = 1'b1;
      p.want  = w;
      return p;
   endfunction

   function automatic string fmt_rsp(gss_pkg::rsp_type o);
      return $sformatf("status=%0d auto=%0d eng=%0d xfr=%0d lamps=%0d/%0d delay=%0d",
                       o.controller_status, o.auto_mode, o.engine_command,
                       o.transfer_command, o.start_lamp, o.stop_lamp, o.delay_running);
   endfunction

   // Pick an event that pushes the sequence along from its current state
   function automatic gss_pkg::req_type next_event();
      logic [REQ_BITS-1:0] raw;
      gss_pkg::req_type    r;
      raw = REQ_BITS'($urandom);
      r   = raw;
      // leave a share as pure noise
      if ($urandom_range(99) < 10) return r;

      r.start_banned       = ($urandom_range(9) == 0);
      r.ban_auto_start     = ($urandom_range(9) == 0);
      r.ban_auto_shutdown  = ($urandom_range(9) == 0);
      r.ban_generator_load = ($urandom_range(9) == 0);
      r.command            = gss_pkg::CMD_TICK;
      case (seq_status)
         gss_pkg::STC_IDLE: begin
            if (!seq_auto) begin
               r.command     = gss_pkg::CMD_SET_MODE;
               r.mode_select = ($urandom_range(4) != 0);
            end else begin
               r.command = gss_pkg::CMD_AUTO_START;
            end
         end
         gss_pkg::STC_START, gss_pkg::STC_START_DLY: begin
            if ($urandom_range(9) < 7) r.engine_state = gss_pkg::ENGST_WORKING;
            r.generator_on_load = ($urandom_range(9) < 7);
            r.remote_start_high = ($urandom_range(9) != 0);
         end
         gss_pkg::STC_WORK: begin
            if ($urandom_range(2) == 0) r.command = gss_pkg::CMD_AUTO_STOP;
         end
         gss_pkg::STC_STOP, gss_pkg::STC_STOP_DLY: begin
            if ($urandom_range(9) < 7) r.engine_state = gss_pkg::ENGST_IDLE;
            r.mains_on_load     = ($urandom_range(9) < 7);
            r.remote_start_high = ($urandom_range(9) == 0);
         end
         gss_pkg::STC_ERROR: begin
            if ($urandom_range(2) != 0) r.command = gss_pkg::CMD_ALARM_RESET;
         end
         default: ;
      endcase

      // recover automatic mode when a sequence is parked in manual
      if (!seq_auto && seq_status != gss_pkg::STC_IDLE && $urandom_range(3) == 0) begin
         r.command     = gss_pkg::CMD_SET_MODE;
         r.mode_select = 1'b1;
      end
      // break sequences now and then
      if ($urandom_range(99) < 4) begin
         case ($urandom_range(3))
            0: r.command = gss_pkg::CMD_EMERG_STOP;
            1: r.command = gss_pkg::CMD_SHUTDOWN;
            2: r.command = gss_pkg::CMD_ALARM_RESET;
            default: r.command = CMD_UNUSED;
         endcase
      end
      return r;
   endfunction

   // Offer one transaction and record its expected result on acceptance
   task automatic send_event(input gss_pkg::req_type r, input bit typed,
                             input gss_pkg::rsp_type want);
      gss_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.data  = r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = sequencer_tick(r);
      expected_tick_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [gss_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [gss_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         gss_pkg::CSR_START_DELAY: cfg_start_delay = value;
         gss_pkg::CSR_STOP_DELAY:  cfg_stop_delay  = value;
         gss_pkg::CSR_UNLOAD:      cfg_unload      = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Drop valid and wait until every expected result is back or the drain limit runs out
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_chan.valid = 1'b0;
      while (expected_tick_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   // Receiver: random stalls plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_result
      gss_pkg::rsp_type want;
      gss_pkg::rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (expected_tick_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", fmt_rsp(got));
         end else begin
            want = expected_tick_results.pop_front();
            if (got.controller_status !== want.controller_status ||
                got.auto_mode         !== want.auto_mode ||
                got.engine_command    !== want.engine_command ||
                got.transfer_command  !== want.transfer_command ||
                got.start_lamp        !== want.start_lamp ||
                got.stop_lamp         !== want.stop_lamp ||
                got.delay_running     !== want.delay_running) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %s, got %s", fmt_rsp(want), fmt_rsp(got));
            end
         end
      end
   end

   // Stimulus
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;

      cfg_start_delay      = '0;
      cfg_stop_delay       = '0;
      cfg_unload           = 1'b0;
      seq_status           = gss_pkg::STC_IDLE;
      seq_auto             = 1'b0;
      seq_start_step       = gss_pkg::SS_IDLE;
      seq_stop_step        = gss_pkg::PS_IDLE;
      seq_delay            = '0;
      seq_fault_after_stop = 1'b0;
      seq_start_lamp       = 1'b0;
      seq_stop_lamp        = 1'b1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk through both sequences and the special cases
      plan.push_back(typed_row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0),
         mk_rsp(gss_pkg::STC_IDLE, 0, gss_pkg::ENG_NONE, gss_pkg::XFR_NONE, 0, 1, 0)));
      // unused code with every other field high acts as a tick
      plan.push_back(typed_row(
         mk_req(CMD_UNUSED, 1, 1, ENGST_OTHER, 1, 1, 1, 1, 1, 1, 1),
         mk_rsp(gss_pkg::STC_IDLE, 0, gss_pkg::ENG_NONE, gss_pkg::XFR_NONE, 0, 1, 0)));
      plan.push_back(typed_row(
         mk_req(gss_pkg::CMD_ALARM_RESET, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0),
         mk_rsp(gss_pkg::STC_IDLE, 0, gss_pkg::ENG_RESET, gss_pkg::XFR_RESET, 0, 1, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_START, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SET_MODE, 0, 1, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0)));
      // delayed start cancelled by a low remote start
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_START, 1, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_START, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 1, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_START, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      // alarm reset while starting is ignored
      plan.push_back(row(
         mk_req(gss_pkg::CMD_ALARM_RESET, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_WORKING, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_WORKING, 1, 0, 1, 0, 0, 0, 0)));
      // delayed stop cancelled by a high remote start
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_STOP, 1, 0, gss_pkg::ENGST_WORKING, 1, 0, 0, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_WORKING, 1, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_STOP, 0, 0, gss_pkg::ENGST_WORKING, 1, 0, 0, 0, 0, 0, 0)));
      // planned stop finishes in manual mode
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SET_MODE, 0, 0, gss_pkg::ENGST_WORKING, 1, 0, 0, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, ENGST_IDLE_SPEED, 0, 1, 0, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_IDLE, 0, 1, 0, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SHUTDOWN, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(
         mk_req(gss_pkg::CMD_EMERG_STOP, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0),
         mk_rsp(gss_pkg::STC_ERROR, 0, gss_pkg::ENG_ESTOP, gss_pkg::XFR_MAINS, 0, 1, 0)));
      // shutdown while in error changes nothing
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SHUTDOWN, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(
         mk_req(gss_pkg::CMD_ALARM_RESET, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 0, 0, 0, 0, 0),
         mk_rsp(gss_pkg::STC_IDLE, 0, gss_pkg::ENG_RESET, gss_pkg::XFR_RESET, 0, 1, 0)));
      // delayed start parked by a switch to manual
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SET_MODE, 0, 1, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_AUTO_START, 1, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_SET_MODE, 0, 0, gss_pkg::ENGST_IDLE, 0, 0, 1, 0, 0, 0, 0)));
      plan.push_back(row(
         mk_req(gss_pkg::CMD_TICK, 0, 0, gss_pkg::ENGST_WORKING, 0, 0, 1, 0, 0, 0, 0)));

      foreach (plan[i]) send_event(plan[i].req, plan[i].typed, plan[i].want);
      wait_for_results();

      // random phases, each with its own configuration and idling
      for (int p = 0; p < 4; p++) begin
         write_reg(gss_pkg::CSR_START_DELAY, phase_start_delay[p]);
         write_reg(gss_pkg::CSR_STOP_DELAY, phase_stop_delay[p]);
         write_reg(gss_pkg::CSR_UNLOAD,
                   {{(gss_pkg::CSR_DATA_WIDTH-1){1'b0}}, phase_unload[p]});
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         // hold the result side so the input backs up
         if (p == 0) hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE) send_event(next_event(), 1'b0, '0);
         wait_for_results();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (10) @(negedge clock);
      if (expected_tick_results.size() != 0) begin
         $display("%0d results never arrived", expected_tick_results.size());
         mismatches += expected_tick_results.size();
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gss_pkg.sv
rtl/gss_req_if.sv
rtl/gss_rsp_if.sv
rtl/gss_step.sv
rtl/genset_start_stop_sequencer.sv
test/genset_start_stop_sequencer_test.sv
